[rtl/assert_macros.svh]
// assertion macros shared by the rtt estimator rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication built on the macro above
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, (cond) |=> (expr), msg)

`endif

[rtl/rtt_pkg.sv]
// package for the rtt retransmission timer estimator
// event kinds, register indexes, reset constants and the clamp helper
package rtt_pkg;

    localparam int unsigned RTO_W   = 20;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CALC_W  = 23;   // wide enough for srtt + 4*dev unclamped

    typedef enum logic [1:0] {
        KIND_NEW_PACKET = 2'd0,
        KIND_RTT_SAMPLE = 2'd1,
        KIND_TIMEOUT    = 2'd2,
        KIND_RESTART    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_MIN_RTO  = 2'd0,
        CFG_MAX_RTO  = 2'd1,
        CFG_MAX_RETX = 2'd2
    } t_cfg_index;

    localparam logic [RTO_W-1:0]   MIN_RTO_RESET  = 20'd1000;
    localparam logic [RTO_W-1:0]   MAX_RTO_RESET  = 20'd3000;
    localparam logic [COUNT_W-1:0] MAX_RETX_RESET = 8'd12;
    localparam logic [RTO_W-1:0]   DEV_INIT       = 20'd150;
    localparam logic [RTO_W-1:0]   RTO_RESTART    = 20'd600;   // 0 + 4*150
    localparam logic [RTO_W-1:0]   RTO_RESET      = 20'd1000;  // 600 clamped by reset limits
    localparam logic [RTO_W-1:0]   RTO_MASK       = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

    // raise to lo first, else lower to hi
    function automatic logic [RTO_W-1:0] clamp_rto(
        input logic [CALC_W-1:0] v,
        input logic [RTO_W-1:0]  lo,
        input logic [RTO_W-1:0]  hi
    );
        logic [RTO_W-1:0] res;
        if (v < {3'd0, lo}) begin
            res = lo;
        end else if (v > {3'd0, hi}) begin
            res = hi;
        end else begin
            res = v[RTO_W-1:0];
        end
        return res;
    endfunction

    // saturate a signed intermediate into 0 .. 2^20-1
    function automatic logic [RTO_W-1:0] sat_u20(input logic signed [CALC_W-1:0] v);
        logic [RTO_W-1:0] res;
        if (v[CALC_W-1]) begin
            res = '0;
        end else if (|v[CALC_W-2:RTO_W]) begin
            res = RTO_MASK;
        end else begin
            res = v[RTO_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/rtt_retransmit_timer_estimator.sv]
// rtt retransmission timer estimator, top level
// depends on rtt_pkg and assert_macros.svh
//
// Integer retransmission-timeout estimator. Each request carries an event kind in
// s_axis_tuser (new packet, rtt sample, timeout, restart) and a sample in
// s_axis_tdata; every request yields exactly one result with the timeout after the
// event, the give-up flag and the retransmit count. A request is registered on
// entry and processed by combinational shifts, adds and clamps into the output
// register, so one request is taken every clock cycle while the result side keeps
// up. With both the input and the output register full the input stalls until the
// result is taken. The estimator state is updated as a request moves from the input
// register to the output register, so back-to-back requests see the previous
// update. Clamp limits and the retransmit limit are written through the cfg port
// (always ready); the user must write them only while no request is in flight, and
// the block itself does not enforce this. The stored timeout only picks up new
// limits at the next event that recomputes it.
`include "assert_macros.svh"

module rtt_retransmit_timer_estimator import rtt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] sample_ms, [23:20] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [19:0] rto_ms, [20] give_up,
                                        // [28:21] retransmit_count, [31:29] zero
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    // configuration
    logic [RTO_W-1:0]   r_min_rto;
    logic [RTO_W-1:0]   r_max_rto;
    logic [COUNT_W-1:0] r_max_retx;

    // estimator state
    logic [RTO_W-1:0]   r_srtt, n_srtt;
    logic [RTO_W-1:0]   r_dev, n_dev;
    logic [RTO_W-1:0]   r_rto, n_rto;
    logic [COUNT_W-1:0] r_retry, n_retry;

    // input stage
    logic               r_in_valid;
    t_kind              r_in_kind;
    logic [RTO_W-1:0]   r_in_sample;

    // output stage
    logic               r_out_valid;
    logic [RTO_W-1:0]   r_out_rto;
    logic               r_out_give_up, n_give_up;
    logic [COUNT_W-1:0] r_out_count;

    logic w_advance;

    logic signed [CALC_W-1:0] w_delta, w_err_step, w_srtt_s;
    logic signed [CALC_W-1:0] w_mag, w_dev_diff, w_dev_step, w_dev_s;
    logic [RTO_W-1:0]         w_srtt_new, w_dev_new;
    logic [CALC_W-1:0]        w_rto_sum, w_rto_dbl;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_count, r_out_give_up, r_out_rto};

    // sample path: srtt += err/8, dev += (|err| - dev)/4, floor rounding
    always_comb begin
        w_delta    = $signed({3'd0, r_in_sample}) - $signed({3'd0, r_srtt});
        w_err_step = w_delta >>> 3;
        w_srtt_s   = $signed({3'd0, r_srtt}) + w_err_step;
        w_mag      = w_delta[CALC_W-1] ? -w_delta : w_delta;
        w_dev_diff = w_mag - $signed({3'd0, r_dev});
        w_dev_step = w_dev_diff >>> 2;
        w_dev_s    = $signed({3'd0, r_dev}) + w_dev_step;
        w_srtt_new = sat_u20(w_srtt_s);
        w_dev_new  = sat_u20(w_dev_s);
        w_rto_sum  = {3'd0, w_srtt_new} + {1'b0, w_dev_new, 2'b00};
        w_rto_dbl  = {2'd0, r_rto, 1'b0};
    end

    always_comb begin
        n_srtt    = r_srtt;
        n_dev     = r_dev;
        n_rto     = r_rto;
        n_retry   = r_retry;
        n_give_up = 1'b0;
        unique case (r_in_kind)
            KIND_NEW_PACKET: begin
                n_retry = '0;
            end
            KIND_RTT_SAMPLE: begin
                n_srtt = w_srtt_new;
                n_dev  = w_dev_new;
                n_rto  = clamp_rto(w_rto_sum, r_min_rto, r_max_rto);
            end
            KIND_TIMEOUT: begin
                n_rto     = clamp_rto(w_rto_dbl, r_min_rto, r_max_rto);
                n_give_up = (r_retry >= r_max_retx);
                if (r_retry != COUNT_MAX) begin
                    n_retry = r_retry + 1'b1;
                end
            end
            KIND_RESTART: begin
                n_srtt = '0;
                n_dev  = DEV_INIT;
                n_rto  = clamp_rto({3'd0, RTO_RESTART}, r_min_rto, r_max_rto);
            end
            default: begin
                n_retry = r_retry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rto   <= MIN_RTO_RESET;
            r_max_rto   <= MAX_RTO_RESET;
            r_max_retx  <= MAX_RETX_RESET;
            r_srtt      <= '0;
            r_dev       <= DEV_INIT;
            r_rto       <= RTO_RESET;
            r_retry     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MIN_RTO:  r_min_rto  <= i_cfg_data;
                    CFG_MAX_RTO:  r_max_rto  <= i_cfg_data;
                    CFG_MAX_RETX: r_max_retx <= i_cfg_data[COUNT_W-1:0];
                    default:      r_max_retx <= r_max_retx;
                endcase
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_srtt      <= n_srtt;
                r_dev       <= n_dev;
                r_rto       <= n_rto;
                r_retry     <= n_retry;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_kind   <= t_kind'(s_axis_tuser);
            r_in_sample <= s_axis_tdata[RTO_W-1:0];
        end
        if (w_advance) begin
            r_out_rto     <= n_rto;
            r_out_give_up <= n_give_up;
            r_out_count   <= n_retry;
        end
    end

    `ASSERT_NEXT(a_new_packet_clears, i_clk, i_rst_n,
        w_advance && r_in_kind == KIND_NEW_PACKET, r_out_count == '0,
        "new packet left a nonzero retransmit count")

    `ASSERT_NEXT(a_give_up_only_timeout, i_clk, i_rst_n,
        w_advance && r_in_kind != KIND_TIMEOUT, !r_out_give_up,
        "give up raised by an event other than timeout")

    `ASSERT_NEXT(a_rto_in_limits, i_clk, i_rst_n,
        w_advance && r_in_kind != KIND_NEW_PACKET && r_min_rto <= r_max_rto,
        r_out_rto >= r_min_rto && r_out_rto <= r_max_rto,
        "recomputed timeout outside the clamp limits")

    `ASSERT_NEXT(a_held_request_kept, i_clk, i_rst_n,
        r_in_valid && !w_advance, r_in_valid && $stable(r_in_sample),
        "pending request dropped or overwritten while stalled")

endmodule
